// ===== rtl/rmq_pkg.sv =====
// rotation matrix to quaternion: shared widths, constants and payload types
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;
    localparam int LANES         = 4;

    // signed radicand and off-diagonal terms, with headroom for three adds
    localparam int VAL_W    = ((FRACTION_BITS > IN_W + 1) ? FRACTION_BITS : IN_W + 1) + 3;
    localparam int MSB_W    = $clog2(VAL_W);
    // magnitudes are normalized so that the largest sits in [2^30, 2^31)
    localparam int MAG_W    = 31;
    localparam int NORM_MSB = MAG_W - 1;
    localparam int SH_W     = $clog2(MAG_W);
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DEN_W    = ROOT_W + 1;
    localparam int QUO_W    = FRACTION_BITS + 1;
    localparam int NUM_W    = MAG_W + FRACTION_BITS + 2;
    localparam int QX_W     = QUO_W + OUT_W;

    localparam logic [OUT_W-1:0] SAT_POS     = OUT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [QX_W-1:0]  SAT_POS_X   = QX_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [QX_W-1:0]  SAT_NEG_X   = QX_W'(64'd1 << (OUT_W - 1));
    localparam logic [OUT_W-1:0] QUAT_ONE    = (FRACTION_BITS >= OUT_W - 1) ? SAT_POS
                                               : OUT_W'(64'd1 << FRACTION_BITS);

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic [SUM_W-1:0]        sum_t;
    typedef logic [ROOT_W-1:0]       root_t;
    typedef logic [OUT_W-1:0]        quat_t;

    // normalized magnitudes, their signs and the degenerate-radicand flag
    typedef struct packed {
        logic             ident;
        logic [LANES-1:0] neg;
        mag_t [LANES-1:0] mag;
    } vec_t;

endpackage

// ===== rtl/rmq_front.sv =====
// front end: branch select, magnitude normalization and sum of squares
// six register stages; uses rmq_pkg
`timescale 1ns / 1ps

module rmq_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [rmq_pkg::IN_W-1:0]   row0_col0,
    input  logic signed [rmq_pkg::IN_W-1:0]   row0_col1,
    input  logic signed [rmq_pkg::IN_W-1:0]   row0_col2,
    input  logic signed [rmq_pkg::IN_W-1:0]   row1_col0,
    input  logic signed [rmq_pkg::IN_W-1:0]   row1_col1,
    input  logic signed [rmq_pkg::IN_W-1:0]   row1_col2,
    input  logic signed [rmq_pkg::IN_W-1:0]   row2_col0,
    input  logic signed [rmq_pkg::IN_W-1:0]   row2_col1,
    input  logic signed [rmq_pkg::IN_W-1:0]   row2_col2,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rmq_pkg::sum_t                     sum,
    output rmq_pkg::vec_t                     vec
);

    localparam int STAGES = 6;
    localparam rmq_pkg::val_t ONE_V = rmq_pkg::VAL_W'(64'd1 << rmq_pkg::FRACTION_BITS);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] src_vld;

    // stage 1: branch select
    rmq_pkg::val_t s1_v_reg [rmq_pkg::LANES];
    logic          s1_ident_reg;
    rmq_pkg::val_t s1_v_next [rmq_pkg::LANES];
    logic          s1_ident_next;

    // stage 2: absolute values and normalizing shift
    logic [rmq_pkg::VAL_W-1:0] s2_mag_reg [rmq_pkg::LANES];
    logic [rmq_pkg::LANES-1:0] s2_neg_reg;
    logic                      s2_ident_reg;
    logic [rmq_pkg::SH_W-1:0]  s2_sh_reg;
    logic [rmq_pkg::VAL_W-1:0] s2_mag_next [rmq_pkg::LANES];
    logic [rmq_pkg::LANES-1:0] s2_neg_next;
    logic [rmq_pkg::SH_W-1:0]  s2_sh_next;

    // stage 3..6
    rmq_pkg::vec_t             s3_vec_reg, s4_vec_reg, s5_vec_reg, s6_vec_reg;
    rmq_pkg::vec_t             s3_vec_next;
    logic [rmq_pkg::SQ_W-1:0]  s4_sq_reg [rmq_pkg::LANES];
    logic [rmq_pkg::SQ_W:0]    s5_pair_reg [2];
    rmq_pkg::sum_t             s6_sum_reg;

    // ready ripples back through full stages; an empty stage is always ready
    always_comb
    begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        src_vld = {vld_reg[STAGES-2:0], in_valid};
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STAGES-1];
    assign sum       = s6_sum_reg;
    assign vec       = s6_vec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= src_vld[k];
                end
            end
        end
    end

    always_comb
    begin
        rmq_pkg::val_t a00, a01, a02, a10, a11, a12, a20, a21, a22, trace, r;
        a00 = rmq_pkg::VAL_W'(row0_col0);
        a01 = rmq_pkg::VAL_W'(row0_col1);
        a02 = rmq_pkg::VAL_W'(row0_col2);
        a10 = rmq_pkg::VAL_W'(row1_col0);
        a11 = rmq_pkg::VAL_W'(row1_col1);
        a12 = rmq_pkg::VAL_W'(row1_col2);
        a20 = rmq_pkg::VAL_W'(row2_col0);
        a21 = rmq_pkg::VAL_W'(row2_col1);
        a22 = rmq_pkg::VAL_W'(row2_col2);
        trace = a00 + a11 + a22;
        // ties between diagonal entries fall through to the later branch
        priority if (trace > rmq_pkg::val_t'(0))
        begin
            r = ONE_V + trace;
            s1_v_next[0] = a21 - a12;
            s1_v_next[1] = a02 - a20;
            s1_v_next[2] = a10 - a01;
            s1_v_next[3] = r;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            r = ONE_V + a00 - a11 - a22;
            s1_v_next[0] = r;
            s1_v_next[1] = a01 + a10;
            s1_v_next[2] = a02 + a20;
            s1_v_next[3] = a21 - a12;
        end
        else if (a11 > a22)
        begin
            r = ONE_V + a11 - a00 - a22;
            s1_v_next[0] = a01 + a10;
            s1_v_next[1] = r;
            s1_v_next[2] = a12 + a21;
            s1_v_next[3] = a02 - a20;
        end
        else
        begin
            r = ONE_V + a22 - a00 - a11;
            s1_v_next[0] = a02 + a20;
            s1_v_next[1] = a12 + a21;
            s1_v_next[2] = r;
            s1_v_next[3] = a10 - a01;
        end
        s1_ident_next = (r <= rmq_pkg::val_t'(0));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && src_vld[0])
        begin
            s1_v_reg     <= s1_v_next;
            s1_ident_reg <= s1_ident_next;
        end
    end

    always_comb
    begin
        logic [rmq_pkg::VAL_W-1:0] big01, big23, big;
        logic [rmq_pkg::MSB_W-1:0] msb;
        for (int i = 0; i < rmq_pkg::LANES; i++)
        begin
            s2_neg_next[i] = s1_v_reg[i][rmq_pkg::VAL_W-1];
            s2_mag_next[i] = s2_neg_next[i] ? rmq_pkg::VAL_W'(-s1_v_reg[i])
                                            : rmq_pkg::VAL_W'(s1_v_reg[i]);
        end
        big01 = (s2_mag_next[0] > s2_mag_next[1]) ? s2_mag_next[0] : s2_mag_next[1];
        big23 = (s2_mag_next[2] > s2_mag_next[3]) ? s2_mag_next[2] : s2_mag_next[3];
        big   = (big01 > big23) ? big01 : big23;
        msb = '0;
        for (int j = 0; j < rmq_pkg::VAL_W; j++)
        begin
            if (big[j])
            begin
                msb = rmq_pkg::MSB_W'(j);
            end
        end
        if (int'(msb) >= rmq_pkg::NORM_MSB)
        begin
            s2_sh_next = '0;
        end
        else
        begin
            s2_sh_next = rmq_pkg::SH_W'(rmq_pkg::NORM_MSB - int'(msb));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1] && src_vld[1])
        begin
            s2_mag_reg   <= s2_mag_next;
            s2_neg_reg   <= s2_neg_next;
            s2_ident_reg <= s1_ident_reg;
            s2_sh_reg    <= s2_sh_next;
        end
    end

    always_comb
    begin
        logic [rmq_pkg::MAG_W+rmq_pkg::VAL_W-1:0] wide;
        s3_vec_next.ident = s2_ident_reg;
        s3_vec_next.neg   = s2_neg_reg;
        for (int i = 0; i < rmq_pkg::LANES; i++)
        begin
            wide = {{rmq_pkg::MAG_W{1'b0}}, s2_mag_reg[i]};
            s3_vec_next.mag[i] = wide[rmq_pkg::MAG_W-1:0] << s2_sh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2] && src_vld[2])
        begin
            s3_vec_reg <= s3_vec_next;
        end
        if (rdy[3] && src_vld[3])
        begin
            s4_vec_reg <= s3_vec_reg;
            for (int i = 0; i < rmq_pkg::LANES; i++)
            begin
                s4_sq_reg[i] <= s3_vec_reg.mag[i] * s3_vec_reg.mag[i];
            end
        end
        if (rdy[4] && src_vld[4])
        begin
            s5_vec_reg     <= s4_vec_reg;
            s5_pair_reg[0] <= {1'b0, s4_sq_reg[0]} + {1'b0, s4_sq_reg[1]};
            s5_pair_reg[1] <= {1'b0, s4_sq_reg[2]} + {1'b0, s4_sq_reg[3]};
        end
        if (rdy[5] && src_vld[5])
        begin
            s6_vec_reg <= s5_vec_reg;
            s6_sum_reg <= rmq_pkg::SUM_W'(s5_pair_reg[0]) + rmq_pkg::SUM_W'(s5_pair_reg[1]);
        end
    end

endmodule

// ===== rtl/rmq_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// carries the normalized vector alongside; uses rmq_pkg
`timescale 1ns / 1ps

module rmq_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rmq_pkg::sum_t  sum,
    input  rmq_pkg::vec_t  vec_in,
    output logic           out_valid,
    input  logic           out_ready,
    output rmq_pkg::root_t root,
    output rmq_pkg::vec_t  vec_out
);

    localparam int STAGES = rmq_pkg::SQRT_STEPS;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] src_vld;

    rmq_pkg::sum_t s_reg   [STAGES];
    rmq_pkg::sum_t res_reg [STAGES];
    rmq_pkg::vec_t vec_reg [STAGES];

    always_comb
    begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        src_vld = {vld_reg[STAGES-2:0], in_valid};
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STAGES-1];
    assign root      = res_reg[STAGES-1][rmq_pkg::ROOT_W-1:0];
    assign vec_out   = vec_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= src_vld[k];
                end
            end
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_step
        localparam rmq_pkg::sum_t BIT = rmq_pkg::sum_t'(1) << (rmq_pkg::SUM_W - 2 - 2 * k);

        rmq_pkg::sum_t s_src, res_src, s_next, res_next;
        rmq_pkg::vec_t vec_src;

        if (k == 0)
        begin : g_first
            assign s_src   = sum;
            assign res_src = '0;
            assign vec_src = vec_in;
        end
        else
        begin : g_rest
            assign s_src   = s_reg[k-1];
            assign res_src = res_reg[k-1];
            assign vec_src = vec_reg[k-1];
        end

        always_comb
        begin
            rmq_pkg::sum_t trial;
            trial = res_src + BIT;
            if (s_src >= trial)
            begin
                s_next   = s_src - trial;
                res_next = (res_src >> 1) + BIT;
            end
            else
            begin
                s_next   = s_src;
                res_next = res_src >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_vld[k])
            begin
                s_reg[k]   <= s_next;
                res_reg[k] <= res_next;
                vec_reg[k] <= vec_src;
            end
        end
    end

endmodule

// ===== rtl/rmq_div.sv =====
// rounding offset, pipelined restoring divider over four lanes, then saturation
// and identity select into the output register; uses rmq_pkg
`timescale 1ns / 1ps

module rmq_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rmq_pkg::root_t root,
    input  rmq_pkg::vec_t  vec,
    output logic           out_valid,
    input  logic           out_ready,
    output rmq_pkg::quat_t quat_x,
    output rmq_pkg::quat_t quat_y,
    output rmq_pkg::quat_t quat_z,
    output rmq_pkg::quat_t quat_w
);

    localparam int DIV_STAGES = rmq_pkg::QUO_W;
    localparam int STAGES     = DIV_STAGES + 2;
    localparam int LN         = rmq_pkg::LANES;

    typedef logic [rmq_pkg::NUM_W-1:0] num_t;
    typedef logic [rmq_pkg::DEN_W-1:0] den_t;
    typedef logic [rmq_pkg::QUO_W-1:0] quo_t;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] src_vld;

    num_t          prep_num_reg [LN];
    den_t          prep_den_reg;
    logic [LN-1:0] prep_neg_reg;
    logic          prep_ident_reg;

    num_t          rem_reg   [DIV_STAGES][LN];
    quo_t          quo_reg   [DIV_STAGES][LN];
    den_t          den_reg   [DIV_STAGES];
    logic [LN-1:0] neg_reg   [DIV_STAGES];
    logic          ident_reg [DIV_STAGES];

    rmq_pkg::quat_t quat_reg [LN];
    rmq_pkg::quat_t quat_next [LN];

    always_comb
    begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        src_vld = {vld_reg[STAGES-2:0], in_valid};
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STAGES-1];
    assign quat_x    = quat_reg[0];
    assign quat_y    = quat_reg[1];
    assign quat_z    = quat_reg[2];
    assign quat_w    = quat_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= src_vld[k];
                end
            end
        end
    end

    // numerator carries the rounding half: (2*mag*2^F + N) / (2*N)
    always_ff @(posedge clk)
    begin
        if (rdy[0] && src_vld[0])
        begin
            for (int i = 0; i < LN; i++)
            begin
                prep_num_reg[i] <= (rmq_pkg::NUM_W'(vec.mag[i]) << (rmq_pkg::FRACTION_BITS + 1))
                                   + rmq_pkg::NUM_W'(root);
            end
            prep_den_reg   <= {root, 1'b0};
            prep_neg_reg   <= vec.neg;
            prep_ident_reg <= vec.ident;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        localparam int SH = DIV_STAGES - 1 - k;

        num_t          rem_src [LN];
        quo_t          quo_src [LN];
        den_t          den_src;
        logic [LN-1:0] neg_src;
        logic          ident_src;
        num_t          rem_next [LN];
        quo_t          quo_next [LN];

        if (k == 0)
        begin : g_first
            assign rem_src   = prep_num_reg;
            assign quo_src   = '{default: '0};
            assign den_src   = prep_den_reg;
            assign neg_src   = prep_neg_reg;
            assign ident_src = prep_ident_reg;
        end
        else
        begin : g_rest
            assign rem_src   = rem_reg[k-1];
            assign quo_src   = quo_reg[k-1];
            assign den_src   = den_reg[k-1];
            assign neg_src   = neg_reg[k-1];
            assign ident_src = ident_reg[k-1];
        end

        always_comb
        begin
            num_t d_sh;
            d_sh = rmq_pkg::NUM_W'(den_src) << SH;
            for (int i = 0; i < LN; i++)
            begin
                if (rem_src[i] >= d_sh)
                begin
                    rem_next[i] = rem_src[i] - d_sh;
                    quo_next[i] = quo_src[i] | (rmq_pkg::QUO_W'(1) << SH);
                end
                else
                begin
                    rem_next[i] = rem_src[i];
                    quo_next[i] = quo_src[i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k+1] && src_vld[k+1])
            begin
                rem_reg[k]   <= rem_next;
                quo_reg[k]   <= quo_next;
                den_reg[k]   <= den_src;
                neg_reg[k]   <= neg_src;
                ident_reg[k] <= ident_src;
            end
        end
    end

    always_comb
    begin
        logic [rmq_pkg::QX_W-1:0] qx;
        for (int i = 0; i < LN; i++)
        begin
            qx = rmq_pkg::QX_W'(quo_reg[DIV_STAGES-1][i]);
            if (!neg_reg[DIV_STAGES-1][i])
            begin
                quat_next[i] = (qx > rmq_pkg::SAT_POS_X) ? rmq_pkg::SAT_POS
                                                         : qx[rmq_pkg::OUT_W-1:0];
            end
            else
            begin
                if (qx > rmq_pkg::SAT_NEG_X)
                begin
                    qx = rmq_pkg::SAT_NEG_X;
                end
                quat_next[i] = rmq_pkg::OUT_W'(~qx + 1'b1);
            end
        end
        // non-positive radicand gives identity
        if (ident_reg[DIV_STAGES-1])
        begin
            quat_next[0] = '0;
            quat_next[1] = '0;
            quat_next[2] = '0;
            quat_next[3] = rmq_pkg::QUAT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[STAGES-1] && src_vld[STAGES-1])
        begin
            quat_reg <= quat_next;
        end
    end

endmodule

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// throughput: one matrix per cycle while out_ready is high; every stage holds one transaction
// the 32-step square root and the FRACTION_BITS+1 step divider set the depth
// a stall halts only the stages that are full, bubbles still advance
// reset (rst_n, asynchronous) clears the stage valid bits only
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [rmq_pkg::IN_W-1:0]   row0_col0,
    input  logic signed [rmq_pkg::IN_W-1:0]   row0_col1,
    input  logic signed [rmq_pkg::IN_W-1:0]   row0_col2,
    input  logic signed [rmq_pkg::IN_W-1:0]   row1_col0,
    input  logic signed [rmq_pkg::IN_W-1:0]   row1_col1,
    input  logic signed [rmq_pkg::IN_W-1:0]   row1_col2,
    input  logic signed [rmq_pkg::IN_W-1:0]   row2_col0,
    input  logic signed [rmq_pkg::IN_W-1:0]   row2_col1,
    input  logic signed [rmq_pkg::IN_W-1:0]   row2_col2,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rmq_pkg::OUT_W-1:0]  quat_x,
    output logic signed [rmq_pkg::OUT_W-1:0]  quat_y,
    output logic signed [rmq_pkg::OUT_W-1:0]  quat_z,
    output logic signed [rmq_pkg::OUT_W-1:0]  quat_w
);

    logic           f_valid, f_ready, r_valid, r_ready;
    rmq_pkg::sum_t  f_sum;
    rmq_pkg::vec_t  f_vec, r_vec;
    rmq_pkg::root_t r_root;

    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .row0_col0 (row0_col0),
        .row0_col1 (row0_col1),
        .row0_col2 (row0_col2),
        .row1_col0 (row1_col0),
        .row1_col1 (row1_col1),
        .row1_col2 (row1_col2),
        .row2_col0 (row2_col0),
        .row2_col1 (row2_col1),
        .row2_col2 (row2_col2),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .sum       (f_sum),
        .vec       (f_vec)
    );

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .sum       (f_sum),
        .vec_in    (f_vec),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .root      (r_root),
        .vec_out   (r_vec)
    );

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .root      (r_root),
        .vec       (r_vec),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w)
    );

    // an open output lets every stage advance, so the input must be open too
    assert property (@(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
        else $error("input blocked while output side is open");

    // each component of a unit quaternion lies within one in magnitude; x and w are checked
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(quat_x) <= $signed(rmq_pkg::QUAT_ONE))
                   && ($signed(quat_x) >= -$signed(rmq_pkg::QUAT_ONE))
                   && ($signed(quat_w) <= $signed(rmq_pkg::QUAT_ONE))
                   && ($signed(quat_w) >= -$signed(rmq_pkg::QUAT_ONE)))
        else $error("quaternion component exceeds one");

    // a transaction in flight from the square root to the divider holds when the divider is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_root))
        else $error("root lost while divider stalled");

endmodule

// ===== dv/rmq_checker.sv =====
// checker for the rotation matrix to quaternion unit: watches both channels,
// predicts each quaternion from the accepted matrix and compares; needs rmq_pkg
`timescale 1ns / 1ps

module rmq_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic signed [rmq_pkg::IN_W-1:0]  row0_col0,
    input  logic signed [rmq_pkg::IN_W-1:0]  row0_col1,
    input  logic signed [rmq_pkg::IN_W-1:0]  row0_col2,
    input  logic signed [rmq_pkg::IN_W-1:0]  row1_col0,
    input  logic signed [rmq_pkg::IN_W-1:0]  row1_col1,
    input  logic signed [rmq_pkg::IN_W-1:0]  row1_col2,
    input  logic signed [rmq_pkg::IN_W-1:0]  row2_col0,
    input  logic signed [rmq_pkg::IN_W-1:0]  row2_col1,
    input  logic signed [rmq_pkg::IN_W-1:0]  row2_col2,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic signed [rmq_pkg::OUT_W-1:0] quat_x,
    input  logic signed [rmq_pkg::OUT_W-1:0] quat_y,
    input  logic signed [rmq_pkg::OUT_W-1:0] quat_z,
    input  logic signed [rmq_pkg::OUT_W-1:0] quat_w,
    output int                               fail_count,
    output int                               pending,
    output int                               quat_seen
);

    typedef struct packed {
        rmq_pkg::quat_t x;
        rmq_pkg::quat_t y;
        rmq_pkg::quat_t z;
        rmq_pkg::quat_t w;
    } quat_rec_t;

    quat_rec_t quat_expected[$];

    function automatic logic [63:0] root64(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic rmq_pkg::quat_t clamp16(input logic neg, input logic [63:0] m);
        if (!neg) return (m > 64'd32767) ? rmq_pkg::quat_t'(32767) : rmq_pkg::quat_t'(m);
        if (m > 64'd32768) m = 64'd32768;
        return rmq_pkg::quat_t'(64'h10000 - m);
    endfunction

    function automatic quat_rec_t to_quat(input longint a [9]);
        longint one;
        longint r;
        longint v [4];
        logic [63:0] mag [4];
        logic neg [4];
        logic [63:0] big;
        logic [63:0] sum;
        logic [63:0] n;
        rmq_pkg::quat_t q [4];
        one = longint'(1) << rmq_pkg::FRACTION_BITS;
        big = 0;
        sum = 0;
        if (a[0] + a[4] + a[8] > 0)
        begin
            r = one + a[0] + a[4] + a[8];
            v = '{a[7] - a[5], a[2] - a[6], a[3] - a[1], r};
        end
        else if (a[0] > a[4] && a[0] > a[8])
        begin
            r = one + a[0] - a[4] - a[8];
            v = '{r, a[1] + a[3], a[2] + a[6], a[7] - a[5]};
        end
        else if (a[4] > a[8])
        begin
            r = one + a[4] - a[0] - a[8];
            v = '{a[1] + a[3], r, a[5] + a[7], a[2] - a[6]};
        end
        else
        begin
            r = one + a[8] - a[0] - a[4];
            v = '{a[2] + a[6], a[5] + a[7], r, a[3] - a[1]};
        end
        if (r <= 0)
            return '{x: 0, y: 0, z: 0, w: clamp16(1'b0, 64'(one))};
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
            if (mag[i] > big) big = mag[i];
        end
        while (big < (64'd1 << 30))
        begin
            big <<= 1;
            for (int i = 0; i < 4; i++) mag[i] <<= 1;
        end
        for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
        n = root64(sum);
        for (int i = 0; i < 4; i++)
            q[i] = clamp16(neg[i],
                           ((mag[i] << (rmq_pkg::FRACTION_BITS + 1)) + n) / (2 * n));
        return '{x: q[0], y: q[1], z: q[2], w: q[3]};
    endfunction

    task automatic compare_field(input string name, input rmq_pkg::quat_t exp_v,
                                 input rmq_pkg::quat_t act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        longint a [9];
        quat_rec_t e;
        if (rst_n && in_valid && in_ready)
        begin
            a = '{row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                  row1_col2, row2_col0, row2_col1, row2_col2};
            quat_expected = {quat_expected, to_quat(a)};
        end
        if (rst_n && out_valid && out_ready)
        begin
            quat_seen++;
            if (quat_expected.size() == 0)
            begin
                $error("quaternion transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                e = quat_expected.pop_front();
                compare_field("quat_x", e.x, quat_x);
                compare_field("quat_y", e.y, quat_y);
                compare_field("quat_z", e.z, quat_z);
                compare_field("quat_w", e.w, quat_w);
            end
        end
        pending <= quat_expected.size();
    end
endmodule

// ===== dv/tb.sv =====
// top of the rotation matrix to quaternion testbench: clock, reset, matrix
// stimulus and verdict; depends on rmq_pkg, rmq_checker and the unit itself
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_MATRICES = 1850;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 80;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic out_ready = 0;
    logic in_ready;
    logic out_valid;
    logic signed [rmq_pkg::IN_W-1:0] m [9];
    logic signed [rmq_pkg::OUT_W-1:0] quat_x, quat_y, quat_z, quat_w;
    int fail_count, pending, quat_seen;
    int idle_cycles = 0;
    bit calm = 0;
    bit draining = 0;

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    initial
        for (int i = 0; i < 9; i++) m[i] = '0;

    rotation_matrix_to_quaternion_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .row0_col0(m[0]), .row0_col1(m[1]), .row0_col2(m[2]),
        .row1_col0(m[3]), .row1_col1(m[4]), .row1_col2(m[5]),
        .row2_col0(m[6]), .row2_col1(m[7]), .row2_col2(m[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
    );

    rmq_checker chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .row0_col0(m[0]), .row0_col1(m[1]), .row0_col2(m[2]),
        .row1_col0(m[3]), .row1_col1(m[4]), .row1_col2(m[5]),
        .row2_col0(m[6]), .row2_col1(m[7]), .row2_col2(m[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .fail_count(fail_count), .pending(pending), .quat_seen(quat_seen)
    );

    // receiver stalls in bursts, none once calm
    initial
    begin
        int n;
        @(posedge clk);
        forever
        begin
            out_ready <= 1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 0;
                n = $urandom_range(1, 9);
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (rst_n && (in_valid || pending > 0 || !draining))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays high across back-to-back transactions and drops only for a gap
    task automatic send_matrix(input logic [rmq_pkg::IN_W-1:0] e [9]);
        int g;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            g = $urandom_range(1, 9);
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        for (int i = 0; i < 9; i++) m[i] <= e[i];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // kind 0: fully random; else rotation-like: signed diagonal within one, off-diagonals within one half
    task automatic send_random(input int kind);
        logic [rmq_pkg::IN_W-1:0] e [9];
        int sgn;
        for (int i = 0; i < 9; i++)
        begin
            if (kind == 0)
                e[i] = rmq_pkg::IN_W'($urandom);
            else if (i % 4 == 0)
            begin
                sgn = $urandom_range(0, 1);
                e[i] = sgn ? rmq_pkg::IN_W'(-$urandom_range(0, 16384))
                           : rmq_pkg::IN_W'($urandom_range(0, 16384));
            end
            else
                e[i] = rmq_pkg::IN_W'($urandom_range(0, 16384) - 8192);
        end
        send_matrix(e);
    endtask

    task automatic send_diag(input int d0, input int d1, input int d2, input int off);
        logic [rmq_pkg::IN_W-1:0] e [9];
        for (int i = 0; i < 9; i++) e[i] = rmq_pkg::IN_W'(off + i * 7);
        e[0] = rmq_pkg::IN_W'(d0);
        e[4] = rmq_pkg::IN_W'(d1);
        e[8] = rmq_pkg::IN_W'(d2);
        send_matrix(e);
    endtask

    initial
    begin
        logic [rmq_pkg::IN_W-1:0] e [9];
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // identity, trace branch, each diagonal branch and ties
        send_diag(16384, 16384, 16384, 0);
        send_diag(16384, -16384, -16384, 0);
        send_diag(-16384, 16384, -16384, 0);
        send_diag(-16384, -16384, 16384, 0);
        send_diag(-100, -100, -100, 30);
        send_diag(0, 0, 0, 5);
        send_diag(-5000, -5000, -9000, 11);
        send_diag(-9000, -3000, -3000, -13);
        // extreme entries at the ends of the input range
        send_diag(-32768, -32768, -32768, 0);
        send_diag(-20000, -32768, -32768, 100);
        send_diag(32767, 32767, 32767, 32767);
        send_diag(32767, -32768, 32767, -32768);
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 9; i++)
                e[i] = (k == 0) ? 16'h8000 : (k == 1) ? 16'h7fff : (k == 2) ? 16'hffff : 16'h0001;
            send_matrix(e);
        end
        in_valid <= 0;
        // hold off until the pipe is empty
        @(posedge clk);
        while (pending > 0) @(posedge clk);
        for (int n = 0; n < RANDOM_MATRICES; n++)
        begin
            if (n > RANDOM_MATRICES - 200) calm = 1;
            send_random($urandom_range(0, 3) == 0 ? 0 : 1);
        end
        in_valid <= 0;
        draining = 1;
        @(posedge clk);
        while (pending > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered trace, diagonal, tie and clamped branches plus %0d random matrices",
                 RANDOM_MATRICES);
        $display("%0d quaternions checked, %0d left waiting", quat_seen, pending);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== rotation_matrix_to_quaternion_unit.f =====
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion_unit.sv
dv/rmq_checker.sv
dv/tb.sv
